/* design/ippd_pkg.sv */
// ----------------------------------------------------------------------------
// ippd_pkg
// Shared types and constants for the pulse-position frame decoder: register
// indexes, reset values of the configuration registers and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ippd_pkg;

  // Number of bit cells in one frame, cell 0 is the start cell.
  localparam int CELLS  = 10;
  localparam int CELL_W = $clog2(CELLS);

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_CELL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_GAP   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPACING = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE       = 3'd4;

  // Register reset values.
  localparam logic [11:0] BIT_CELL_RST    = 12'd440;
  localparam logic [15:0] FRAME_GAP_RST   = 16'd2500;
  localparam logic [9:0]  MIN_SPACING_RST = 10'd80;
  localparam logic [15:0] TOLERANCE_RST   = 16'd170;
  localparam logic [12:0] PHASE_RST       = 13'd0;

  // Largest slot distance, also the start value of the nearest-pulse search.
  localparam logic [15:0] DIST_MAX = 16'hFFFF;

  // Event kinds carried on the input tuser bit.
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;    // register the accepted input item
    logic              edge_evt;   // apply a falling-edge event
    logic              dec_init;   // start decoding the open frame
    logic              slot_init;  // compute slot target, restart search
    logic              rd_issue;   // read the next stored pulse
    logic              next_cell;  // advance the cell base time
    logic              slot_done;  // fold the search result into the cell
    logic              load_out;   // load the result and close the frame
    logic              zero_slot;  // current slot is the half-cell slot
    logic [CELL_W-1:0] cell_idx;   // current cell number
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_poll;    // captured item is a poll tick
    logic pending;    // a frame is open
    logic expired;    // frame window has run out at the captured time
    logic any_pulse;  // at least one pulse offset is stored
    logic scan_last;  // the read being issued is the last stored pulse
    logic out_busy;   // output register holds a result not taken this cycle
  } stat_t;

endpackage

/* design/ir_pulse_position_frame_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_position_frame_decoder
// Decodes ten-cell pulse-position infrared frames with odd parity from
// time-stamped falling-edge and poll events.
//
//   Channel  Dir  Signals                     Contents
//   in       in   in_tvalid/tready/tdata/tuser tdata: now_us[31:0];
//                                             tuser: func
//   out      out  out_tvalid/tready/tdata     scancode, frame_good, cell_bits,
//                                             unknown_cells, pulses_seen,
//                                             overflowed
//   cfg      in   cfg_wr_en/addr/wdata        five registers, write only
//
// An edge or a poll that does not decode is only captured and evaluated.
// A decoding poll also searches all stored pulses for both slots of each of
// cells 1 to 9 and then loads the result; the single read port of the pulse
// store, one pulse per cycle, sets the length of this search.
// Reset is synchronous and clears the frame and the registers to defaults.
// A new item is accepted while a result waits; a finished decode waits only
// if the previous result has not been taken.
// ----------------------------------------------------------------------------
module ir_pulse_position_frame_decoder #(
  parameter int MAX_PULSES = 24,
  localparam int CNT_W = $clog2(MAX_PULSES + 1),
  localparam int OUT_W = ((30 + CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input events.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // now_us[31:0]
  input  logic [0:0]                      in_tuser,   // func
  // Results.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // scancode[7:0], frame_good, cell_bits[9:0], unknown_cells[9:0],
  // pulses_seen[CNT_W-1:0], overflowed, zero fill
  output logic [OUT_W-1:0]                out_tdata,
  // Configuration writes.
  input  logic                            cfg_wr_en,
  input  logic [ippd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ippd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import ippd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ippd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ippd_datapath #(
    .MAX_PULSES (MAX_PULSES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_func    (in_tuser[0]),
    .in_now     (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/ippd_ram.sv */
// ----------------------------------------------------------------------------
// ippd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ippd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ippd_datapath.sv */
// ----------------------------------------------------------------------------
// ippd_datapath
// Configuration registers, frame state, pulse offset store, nearest-pulse
// search per slot, cell result registers and the output register.
// ----------------------------------------------------------------------------
module ippd_datapath #(
  parameter int MAX_PULSES = 24,
  localparam int CNT_W  = $clog2(MAX_PULSES + 1),
  localparam int ADDR_W = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1,
  localparam int OUT_W  = ((30 + CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ippd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ippd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_func,
  input  logic [31:0]                     in_now,
  input  ippd_pkg::cmd_t                  cmd,
  output ippd_pkg::stat_t                 stat,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [OUT_W-1:0]                out_tdata
);

  import ippd_pkg::*;

  // Configuration registers.
  logic [11:0]        bit_cell_r;
  logic [15:0]        frame_gap_r;
  logic [9:0]         min_spacing_r;
  logic [15:0]        tolerance_r;
  logic signed [12:0] phase_r;
  logic [16:0]        window_r;

  // Captured input item.
  logic        func_r;
  logic [31:0] now_r;

  // Frame state.
  logic             pending_r;
  logic [31:0]      start_r;
  logic [31:0]      last_r;
  logic [CNT_W-1:0] total_r;
  logic             ovf_r;

  // Decode working registers.
  logic [16:0]       base_r;
  logic [15:0]       target_r;
  logic [15:0]       best_r;
  logic [15:0]       d1_r;
  logic              one_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              cmp_en_r;
  logic [CELLS-1:0]  bits_r;
  logic [CELLS-1:0]  unknown_r;

  // Output register.
  logic             out_valid_r;
  logic [7:0]       o_scancode_r;
  logic             o_ok_r;
  logic [CELLS-1:0] o_raw_r;
  logic [CELLS-1:0] o_unknown_r;
  logic [CNT_W-1:0] o_pulses_r;
  logic             o_ovf_r;

  logic [31:0]        since_last;
  logic [31:0]        since_start;
  logic               spaced;
  logic               store_room;
  logic               ram_we;
  logic [15:0]        ram_rdata;
  logic [16:0]        slot_sum;
  logic signed [18:0] slot_s;
  logic [15:0]        slot_clamped;
  logic [15:0]        pulse_dist;
  logic               present;
  logic               parity_odd;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cell_r    <= BIT_CELL_RST;
      frame_gap_r   <= FRAME_GAP_RST;
      min_spacing_r <= MIN_SPACING_RST;
      tolerance_r   <= TOLERANCE_RST;
      phase_r       <= PHASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_BIT_CELL:    bit_cell_r    <= cfg_wdata[11:0];
        REG_FRAME_GAP:   frame_gap_r   <= cfg_wdata;
        REG_MIN_SPACING: min_spacing_r <= cfg_wdata[9:0];
        REG_TOLERANCE:   tolerance_r   <= cfg_wdata;
        REG_PHASE:       phase_r       <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Frame window, ten cells plus the gap; ten times is eight plus two.
  always_ff @(posedge clk) begin
    window_r <= {2'b00, bit_cell_r, 3'b000} + {4'b0000, bit_cell_r, 1'b0}
              + {1'b0, frame_gap_r};
  end

  // Capture of the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      now_r  <= in_now;
    end
  end

  // Edge spacing and store checks.
  assign since_last  = now_r - last_r;
  assign since_start = now_r - start_r;
  assign spaced      = since_last >= {22'd0, min_spacing_r};
  assign store_room  = total_r < CNT_W'(MAX_PULSES);
  assign ram_we      = cmd.edge_evt && pending_r && spaced && store_room;

  // Frame state: opened by the first edge, filled by spaced edges,
  // closed when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      start_r   <= '0;
      last_r    <= '0;
      total_r   <= '0;
      ovf_r     <= 1'b0;
    end else if (cmd.edge_evt) begin
      if (!pending_r) begin
        pending_r <= 1'b1;
        start_r   <= now_r;
        last_r    <= now_r;
        total_r   <= '0;
        ovf_r     <= 1'b0;
      end else if (spaced) begin
        last_r <= now_r;
        if (store_room) begin
          total_r <= total_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end else if (cmd.load_out) begin
      pending_r <= 1'b0;
      total_r   <= '0;
      ovf_r     <= 1'b0;
    end
  end

  ippd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PULSES)
  ) u_offsets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[ADDR_W-1:0]),
    .wdata (since_start[15:0]),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Slot time: cell base plus half a cell for the zero slot, shifted by the
  // phase offset and clamped to 16 bits.
  assign slot_sum = base_r + (cmd.zero_slot ? {6'd0, bit_cell_r[11:1]} : 17'd0);
  assign slot_s   = $signed({2'b00, slot_sum}) + $signed({{6{phase_r[12]}}, phase_r});

  always_comb begin
    if (slot_s < 0) begin
      slot_clamped = 16'd0;
    end else if (slot_s > $signed({3'b000, DIST_MAX})) begin
      slot_clamped = DIST_MAX;
    end else begin
      slot_clamped = slot_s[15:0];
    end
  end

  // Distance of the stored pulse read last cycle to the slot.
  assign pulse_dist = (ram_rdata > target_r) ? ram_rdata - target_r : target_r - ram_rdata;

  // Search control: read index and compare enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd_issue;
      if (cmd.slot_init) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  // Nearest-pulse search and cell results.
  assign present = (total_r != '0) && (best_r <= tolerance_r);

  always_ff @(posedge clk) begin
    if (cmd.dec_init) begin
      base_r    <= {5'd0, bit_cell_r};
      bits_r    <= CELLS'(1);
      unknown_r <= '0;
    end else if (cmd.next_cell) begin
      base_r <= base_r + {5'd0, bit_cell_r};
    end
    if (cmd.slot_init) begin
      target_r <= slot_clamped;
      best_r   <= DIST_MAX;
    end else if (cmp_en_r && (pulse_dist < best_r)) begin
      best_r <= pulse_dist;
    end
    if (cmd.slot_done) begin
      if (!cmd.zero_slot) begin
        one_r <= present;
        d1_r  <= best_r;
      end else if (!one_r && !present) begin
        unknown_r[cmd.cell_idx] <= 1'b1;
      end else if (one_r && (!present || (d1_r <= best_r))) begin
        bits_r[cmd.cell_idx] <= 1'b1;
      end
    end
  end

  // Odd parity over the data and parity cells.
  assign parity_odd = ^bits_r[CELLS-1:1];

  // Output register, refilled only when empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_scancode_r <= bits_r[8:1];
      o_ok_r       <= !ovf_r && (unknown_r == '0) && parity_odd;
      o_raw_r      <= bits_r;
      o_unknown_r  <= unknown_r;
      o_pulses_r   <= total_r;
      o_ovf_r      <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({o_ovf_r, o_pulses_r, o_unknown_r, o_raw_r, o_ok_r,
                              o_scancode_r});

  // Status toward the controller.
  always_comb begin
    stat.is_poll   = (func_r == FUNC_POLL);
    stat.pending   = pending_r;
    stat.expired   = since_start >= {15'd0, window_r};
    stat.any_pulse = (total_r != '0);
    stat.scan_last = (CNT_W'(rd_idx_r) + 1'b1) == total_r;
    stat.out_busy  = out_valid_r && !out_tready;
  end

endmodule

/* design/ippd_ctrl.sv */
// ----------------------------------------------------------------------------
// ippd_ctrl
// Controller state machine: takes one item, applies an edge or checks a poll;
// on a decode it walks cells 1 to 9, two slots each, through the pulse search.
// ----------------------------------------------------------------------------
module ippd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ippd_pkg::stat_t stat,
  output ippd_pkg::cmd_t  cmd
);

  import ippd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_TGT   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_SLOT  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [CELL_W-1:0] CELL_FIRST = CELL_W'(1);
  localparam logic [CELL_W-1:0] CELL_LAST  = CELL_W'(CELLS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              slot_r, slot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cell_r  <= CELL_FIRST;
      slot_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cell_r  <= cell_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cell_nxt      = cell_r;
    slot_nxt      = slot_r;
    cmd           = '0;
    cmd.zero_slot = slot_r;
    cmd.cell_idx  = cell_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat.is_poll) begin
          cmd.edge_evt = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.pending && stat.expired) begin
          cmd.dec_init = 1'b1;
          cell_nxt     = CELL_FIRST;
          slot_nxt     = 1'b0;
          state_nxt    = S_TGT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TGT: begin
        cmd.slot_init = 1'b1;
        state_nxt     = stat.any_pulse ? S_SCAN : S_DRAIN;
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        cmd.slot_done = 1'b1;
        if (!slot_r) begin
          slot_nxt  = 1'b1;
          state_nxt = S_TGT;
        end else if (cell_r == CELL_LAST) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_cell = 1'b1;
          cell_nxt      = cell_r + 1'b1;
          slot_nxt      = 1'b0;
          state_nxt     = S_TGT;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-position frame decoder. Time-stamped edge
// and poll items are streamed in with random gaps. A behavioral copy of the
// decoder predicts each frame result, and the monitor compares every result
// field by field while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ippd_pkg::*;

  localparam int PULSE_CAP = 24;
  localparam int OUT_W     = 40;
  localparam int RES_W     = 35;

  // Register indexes that have no register behind them.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

  // Fields of one result item, scancode in the lowest bits.
  typedef struct packed {
    logic       overflowed;
    logic [4:0] pulses_seen;
    logic [9:0] unknown_cells;
    logic [9:0] cell_bits;
    logic       frame_good;
    logic [7:0] scancode;
  } frame_result_t;

  typedef struct packed {
    logic        func;
    logic [31:0] now_us;
  } rx_event_t;

  typedef enum int {
    FRAME_CLEAN, FRAME_BAD_PARITY, FRAME_MISSING, FRAME_CROWDED,
    FRAME_OVERFLOW, FRAME_LATE, FRAME_LOOSE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // now_us[31:0]
  logic [0:0]            in_tuser = '0;   // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // scancode, frame_good, cell_bits,
                                          // unknown_cells, pulses_seen,
                                          // overflowed, zero fill
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ir_pulse_position_frame_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Register copies used for prediction and for timing the stimulus.
  logic [11:0]        cell_us    = BIT_CELL_RST;
  logic [15:0]        gap_us     = FRAME_GAP_RST;
  logic [9:0]         spacing_us = MIN_SPACING_RST;
  logic [15:0]        tol_us     = TOLERANCE_RST;
  logic signed [12:0] phase_us   = PHASE_RST;

  // Frame state of the predicted decoder.
  logic        frame_open = 1'b0;
  logic [31:0] frame_t0 = '0;
  logic [31:0] last_edge_t = '0;
  logic [15:0] pulse_store [PULSE_CAP];
  int unsigned pulse_cnt = 0;
  logic        pulse_ovf = 1'b0;

  frame_result_t expected_frames [$];
  rx_event_t     event_q [$];
  rx_event_t     next_event;
  frame_result_t got_res, want_res;

  int          error_count = 0;
  int          results_seen = 0;
  int unsigned stim_count = 0;
  logic [31:0] stim_time;
  int unsigned sender_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  logic        held_once = 1'b0;
  logic [9:0]  cycle_cnt = '0;
  logic        quiet;

  // A quarter of the time neither side idles.
  assign quiet = (cycle_cnt[9:8] == 2'b00);
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1'b1;

  // Mostly short idle stretches, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Shift a slot time by the phase offset and clamp it to 16 bits.
  function automatic int unsigned clamp_slot(int base_us);
    int t;
    t = base_us + int'(phase_us);
    if (t < 0) return 0;
    if (t > 65535) return 65535;
    return t;
  endfunction

  // Distance from a slot to the nearest stored pulse.
  function automatic int unsigned nearest_dist(int unsigned target);
    int unsigned best, d, p;
    best = 65535;
    for (int i = 0; i < pulse_cnt; i++) begin
      p = pulse_store[i];
      d = (p > target) ? p - target : target - p;
      if (d < best) best = d;
    end
    return best;
  endfunction

  // Apply one accepted item to the predicted decoder state.
  function automatic void decode_event(logic func, logic [31:0] now);
    logic [31:0]   elapsed;
    logic [31:0]   window;
    logic [9:0]    bits, unknown;
    int unsigned   start, d1, d0;
    logic          one_hit, zero_hit;
    frame_result_t res;
    if (func == FUNC_EDGE) begin
      if (!frame_open) begin
        frame_open  = 1'b1;
        frame_t0    = now;
        last_edge_t = now;
        pulse_cnt   = 0;
        pulse_ovf   = 1'b0;
      end else if (now - last_edge_t >= {22'd0, spacing_us}) begin
        last_edge_t = now;
        if (pulse_cnt < PULSE_CAP) begin
          pulse_store[pulse_cnt] = now[15:0] - frame_t0[15:0];
          pulse_cnt++;
        end else begin
          pulse_ovf = 1'b1;
        end
      end
      return;
    end
    elapsed = now - frame_t0;
    window  = CELLS * cell_us + gap_us;
    if (!frame_open || elapsed < window) return;
    bits    = 10'd1;
    unknown = '0;
    for (int c = 1; c < CELLS; c++) begin
      start    = c * cell_us;
      d1       = nearest_dist(clamp_slot(start));
      d0       = nearest_dist(clamp_slot(start + cell_us / 2));
      one_hit  = (pulse_cnt != 0) && (d1 <= tol_us);
      zero_hit = (pulse_cnt != 0) && (d0 <= tol_us);
      if (!one_hit && !zero_hit) unknown[c] = 1'b1;
      else if (one_hit && (!zero_hit || d1 <= d0)) bits[c] = 1'b1;
    end
    res.scancode      = bits[8:1];
    res.frame_good    = !pulse_ovf && (unknown == '0) && ($countones(bits[9:1]) % 2 == 1);
    res.cell_bits     = bits;
    res.unknown_cells = unknown;
    res.pulses_seen   = pulse_cnt[4:0];
    res.overflowed    = pulse_ovf;
    expected_frames.push_back(res);
    frame_open = 1'b0;
    pulse_cnt  = 0;
    pulse_ovf  = 1'b0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Sender: present queued items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      sender_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) decode_event(in_tuser[0], in_tdata);
      if (!in_tvalid || in_tready) begin
        if (sender_gap != 0) begin
          in_tvalid  <= 1'b0;
          sender_gap <= sender_gap - 1;
        end else if (event_q.size() != 0) begin
          next_event = event_q.pop_front();
          in_tvalid  <= 1'b1;
          in_tdata   <= next_event.now_us;
          in_tuser   <= next_event.func;
          sender_gap <= quiet ? 0 : idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result item and stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = frame_result_t'(out_tdata[RES_W-1:0]);
        if (expected_frames.size() == 0) begin
          $error("result item with no frame expected: 0x%0h", out_tdata);
          error_count++;
        end else begin
          want_res = expected_frames.pop_front();
          check_field("scancode", want_res.scancode, got_res.scancode);
          check_field("frame_good", want_res.frame_good, got_res.frame_good);
          check_field("cell_bits", want_res.cell_bits, got_res.cell_bits);
          check_field("unknown_cells", want_res.unknown_cells, got_res.unknown_cells);
          check_field("pulses_seen", want_res.pulses_seen, got_res.pulses_seen);
          check_field("overflowed", want_res.overflowed, got_res.overflowed);
          check_field("fill", 0, out_tdata[OUT_W-1:RES_W]);
        end
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!held_once && results_seen == 8) begin
        // One long hold-off so that the decoder fills up and stalls its input.
        held_once  <= 1'b1;
        hold_left  <= 3000;
        out_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        out_tready <= 1'b0;
        rx_stall   <= rx_stall - 1;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) rx_stall <= idle_len();
      end
    end
  end

  task automatic push_event(logic func, logic [31:0] at);
    rx_event_t ev;
    ev.func   = func;
    ev.now_us = at;
    event_q.push_back(ev);
    stim_count++;
  endtask

  // Queue one frame built from the current register copies.
  task automatic push_frame(frame_kind_t kind);
    logic [31:0] t0, at, t_end;
    logic [7:0]  code;
    logic [9:0]  cells;
    int unsigned cell_len, jit, window, drop, extra;
    int          j;
    cell_len = cell_us;
    jit      = cell_len / 6;
    window   = CELLS * cell_len + gap_us;
    code     = 8'($urandom);
    cells    = {~(^code), code, 1'b1};
    if (kind == FRAME_BAD_PARITY) cells[9] = ~cells[9];
    drop = (kind == FRAME_MISSING) ? $urandom_range(1, 9) : 0;
    t0   = stim_time + $urandom_range(1, 3000);
    push_event(FUNC_EDGE, t0);
    at = t0;
    for (int c = 1; c < CELLS; c++) begin
      j = int'($urandom_range(0, 2 * jit)) - int'(jit);
      if (kind == FRAME_LOOSE) j = j * 4;
      at = t0 + c * cell_len + (cells[c] ? 0 : cell_len / 2) + j;
      if (c != drop) push_event(FUNC_EDGE, at);
      // Crowded frames add edges at or just inside the minimum spacing.
      if (kind == FRAME_CROWDED && $urandom_range(0, 2) == 0)
        push_event(FUNC_EDGE, at + $urandom_range(0, spacing_us));
    end
    if (kind == FRAME_OVERFLOW) begin
      // Fifteen extras fill the store exactly, more spill over.
      extra = $urandom_range(15, 22);
      at    = t0 + CELLS * cell_len;
      repeat (extra) begin
        at = at + spacing_us + $urandom_range(1, 40);
        push_event(FUNC_EDGE, at);
      end
    end
    if (window != 0 && $urandom_range(0, 1) == 0)
      push_event(FUNC_POLL, t0 + $urandom_range(0, window - 1));
    if (kind == FRAME_LATE) begin
      push_event(FUNC_EDGE, t0 + window + $urandom_range(0, 300));
      t_end = t0 + window + $urandom_range(400, 900);
    end else begin
      t_end = t0 + window + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200));
    end
    push_event(FUNC_POLL, t_end);
    stim_time = t_end;
  endtask

  // Loose edges and polls, then a poll far enough out to close any frame.
  task automatic push_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) begin
        push_event(FUNC_POLL, $urandom);
      end else begin
        stim_time = stim_time + $urandom_range(0, 2 * spacing_us + 5);
        push_event(1'($urandom_range(0, 1)), stim_time);
      end
    end
    stim_time = stim_time + 200000;
    push_event(FUNC_POLL, stim_time);
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned first, r;
    first = stim_count;
    while (stim_count - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) push_frame(FRAME_CLEAN);
      else if (r < 58) push_frame(FRAME_BAD_PARITY);
      else if (r < 66) push_frame(FRAME_MISSING);
      else if (r < 74) push_frame(FRAME_CROWDED);
      else if (r < 80) push_frame(FRAME_OVERFLOW);
      else if (r < 86) push_frame(FRAME_LATE);
      else if (r < 92) push_frame(FRAME_LOOSE);
      else push_noise();
    end
  endtask

  // Wait until every queued item is in and every result is out.
  task automatic wait_idle();
    while (event_q.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Unused upper bits of the write data carry random junk.
  function automatic logic [15:0] with_junk(int unsigned value, int unsigned width);
    logic [31:0] mask;
    mask = (32'h1 << width) - 1;
    return 16'((value & mask) | ($urandom << width));
  endfunction

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_BIT_CELL:    cell_us    = value[11:0];
      REG_FRAME_GAP:   gap_us     = value;
      REG_MIN_SPACING: spacing_us = value[9:0];
      REG_TOLERANCE:   tol_us     = value;
      REG_PHASE:       phase_us   = value[12:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(int unsigned cell_len, int unsigned gap, int unsigned spacing,
                         int unsigned tol, int phase);
    cfg_write(REG_BIT_CELL, with_junk(cell_len, 12));
    cfg_write(REG_FRAME_GAP, with_junk(gap, 16));
    cfg_write(REG_MIN_SPACING, with_junk(spacing, 10));
    cfg_write(REG_TOLERANCE, with_junk(tol, 16));
    cfg_write(REG_PHASE, with_junk(phase, 13));
  endtask

  // Stimulus and end of run.
  initial begin
    logic [31:0] t0;
    int unsigned cell_len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Poll with no frame open.
    push_event(FUNC_POLL, 32'hFFFF_FFFF);
    // All-ones frame that wraps the time counter, with one edge too close.
    t0 = 32'hFFFF_F000;
    push_event(FUNC_EDGE, t0);
    push_event(FUNC_EDGE, t0 + 10);
    for (int c = 1; c < CELLS; c++) push_event(FUNC_EDGE, t0 + c * 440);
    // One poll just inside the window, one right on its end.
    push_event(FUNC_POLL, t0 + 6899);
    push_event(FUNC_POLL, t0 + 6900);
    // Zero bits in cells 2 to 8 and a one in cell 9, with cell 1 placed midway between its two slots.
    t0 = t0 + 20000;
    push_event(FUNC_EDGE, t0);
    for (int c = 1; c < CELLS; c++)
      push_event(FUNC_EDGE, t0 + c * 440 + ((c == 1) ? 110 : (c == 9) ? 0 : 220));
    push_event(FUNC_POLL, t0 + 6901);
    // Frame with no stored pulse: every cell from 1 to 9 is unknown.
    t0 = t0 + 30000;
    push_event(FUNC_EDGE, t0);
    push_event(FUNC_POLL, t0 + 200000);
    stim_time = t0 + 200000;
    run_random(200);
    wait_idle();

    // Lowest settings.
    cfg_all(1, 0, 0, 0, -4096);
    run_random(80);
    wait_idle();

    // Highest settings.
    cfg_all(4095, 65535, 1023, 65535, 4095);
    run_random(80);
    wait_idle();

    // Zero cell length by masking, and writes to unused indexes.
    cfg_write(REG_BIT_CELL, 16'hF000);
    cfg_write(REG_MIN_SPACING, with_junk($urandom_range(0, 200), 10));
    cfg_write(REG_UNUSED_LO, 16'($urandom));
    cfg_write(REG_UNUSED_HI, 16'($urandom));
    run_random(40);
    wait_idle();

    // Typical timing with a small phase shift.
    cell_len = $urandom_range(350, 600);
    cfg_all(cell_len, $urandom_range(1000, 4000), $urandom_range(30, 100),
            $urandom_range(cell_len / 5, cell_len / 3), int'($urandom_range(0, 120)) - 60);
    run_random(180);
    wait_idle();

    // Wider random settings.
    cell_len = $urandom_range(100, 1000);
    cfg_all(cell_len, $urandom_range(0, 3000), $urandom_range(0, cell_len / 3),
            $urandom_range(0, cell_len / 2), int'($urandom_range(0, 400)) - 200);
    run_random(195);
    wait_idle();

    if (error_count == 0) begin
      $display("PASS ir_pulse_position_frame_decoder");
    end else begin
      $display("FAIL ir_pulse_position_frame_decoder");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30000000;
    $display("FAIL ir_pulse_position_frame_decoder");
    $finish;
  end

endmodule

/* ir_pulse_position_frame_decoder.f */
design/ippd_pkg.sv
design/ippd_ram.sv
design/ippd_datapath.sv
design/ippd_ctrl.sv
design/ir_pulse_position_frame_decoder.sv
verif/tb_top.sv
